/* rtl/core/pgb_pkg.sv */
// pgb_pkg: shared types, codes and constants for the glyph blitter.
// No dependencies; used by pgb_apb_regs and page_display_glyph_blitter.
package pgb_pkg;

    localparam int unsigned FONT_BYTES_DEF     = 4096;
    localparam int unsigned SCREEN_COLUMNS_DEF = 128;
    localparam int unsigned SCREEN_PAGES_DEF   = 8;

    localparam int unsigned CALC_W   = 17;
    localparam int unsigned MUL_A_W  = 9;
    localparam int unsigned MUL_B_W  = 8;
    localparam int unsigned ROWS_W   = 4;
    localparam int unsigned GW_W     = 6;
    localparam int unsigned BYTE_W   = 8;

    localparam int unsigned S_TDATA_W = 64;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 8;
    localparam int unsigned M_TUSER_W = 1;

    localparam int unsigned PADDR_W = 4;
    localparam int unsigned PDATA_W = 32;

    localparam logic [1:0] REG_GLYPH_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GLYPH_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FIRST_CODE   = 2'd2;

    localparam logic [5:0] GLYPH_WIDTH_RST  = 6'd5;
    localparam logic [5:0] GLYPH_HEIGHT_RST = 6'd7;
    localparam logic [7:0] FIRST_CODE_RST   = 8'd32;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_DRAW = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [1:0] INK_SET    = 2'd1;
    localparam logic [1:0] INK_INVERT = 2'd2;

    typedef struct packed {
        logic [5:0] glyph_width;
        logic [5:0] glyph_height;
        logic [7:0] first_code;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_CHECK,
        ST_COUNT,
        ST_FONT_RD,
        ST_FONT_DATA,
        ST_UP_RD,
        ST_UP_WR,
        ST_LO_RD,
        ST_LO_WR,
        ST_NEXT,
        ST_DISP_DATA,
        ST_DONE
    } state_t;

endpackage

/* rtl/core/pgb_apb_regs.sv */
// pgb_apb_regs: APB register file for glyph geometry and first code.
// Depends on pgb_pkg.
module pgb_apb_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pgb_pkg::PADDR_W-1:0]   paddr,
    input  logic [pgb_pkg::PDATA_W-1:0]   pwdata,
    output logic [pgb_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output pgb_pkg::cfg_t                 cfg
);

    pgb_pkg::cfg_t cfg_reg;
    pgb_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                pgb_pkg::REG_GLYPH_WIDTH:  cfg_next.glyph_width  = pwdata[5:0];
                pgb_pkg::REG_GLYPH_HEIGHT: cfg_next.glyph_height = pwdata[5:0];
                pgb_pkg::REG_FIRST_CODE:   cfg_next.first_code   = pwdata[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            pgb_pkg::REG_GLYPH_WIDTH:  prdata = 32'(cfg_reg.glyph_width);
            pgb_pkg::REG_GLYPH_HEIGHT: prdata = 32'(cfg_reg.glyph_height);
            pgb_pkg::REG_FIRST_CODE:   prdata = 32'(cfg_reg.first_code);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_width  <= pgb_pkg::GLYPH_WIDTH_RST;
            cfg_reg.glyph_height <= pgb_pkg::GLYPH_HEIGHT_RST;
            cfg_reg.first_code   <= pgb_pkg::FIRST_CODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/page_display_glyph_blitter.sv */
// page_display_glyph_blitter: top level; sequencer, shared multiplier, font and display memories.
// Depends on pgb_pkg and pgb_apb_regs.
//
// Draws proportional font glyphs into a page-organised display memory, one word in, one word
// out. After reset a clearing pass zeroes all SCREEN_COLUMNS*SCREEN_PAGES display bytes
// (1024 by default), with s_tready low. A load writes the font byte as the word is taken; a
// read fetches the display byte and registers it as the result. A draw first uses one
// multiplier twice for the record address, then reads each glyph column byte from font memory
// and does a read-modify-write on the display page it lies on, and on the next page when it
// spans two; a byte that is off-screen is skipped. s_tready is high only between items; a
// finished word waits in the output register while the next item is taken.
module page_display_glyph_blitter
#(
    parameter int unsigned FONT_BYTES     = pgb_pkg::FONT_BYTES_DEF,
    parameter int unsigned SCREEN_COLUMNS = pgb_pkg::SCREEN_COLUMNS_DEF,
    parameter int unsigned SCREEN_PAGES   = pgb_pkg::SCREEN_PAGES_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // font_addr[11:0] font_byte[19:12] char_code[27:20] pos_x[35:28] pos_y[43:36]
    // ink[45:44] transparent[46] read_col[53:47] read_page[56:54], zero above
    input  logic [pgb_pkg::S_TDATA_W-1:0]   s_tdata,
    // req_type[1:0]
    input  logic [pgb_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // result_value[7:0]
    output logic [pgb_pkg::M_TDATA_W-1:0]   m_tdata,
    // bad_glyph[0]
    output logic [pgb_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pgb_pkg::PADDR_W-1:0]     paddr,
    input  logic [pgb_pkg::PDATA_W-1:0]     pwdata,
    output logic [pgb_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);

    localparam int unsigned DISP_DEPTH = SCREEN_COLUMNS * SCREEN_PAGES;
    localparam int unsigned DISP_AW    = $clog2(DISP_DEPTH);
    localparam int unsigned FONT_AW    = $clog2(FONT_BYTES);
    localparam int unsigned CW         = pgb_pkg::CALC_W;

    pgb_pkg::cfg_t cfg;

    pgb_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input word fields
    logic [11:0] in_font_addr;
    logic [7:0]  in_font_byte;
    logic [7:0]  in_char_code;
    logic [7:0]  in_pos_x;
    logic [7:0]  in_pos_y;
    logic [1:0]  in_ink;
    logic        in_transparent;
    logic [6:0]  in_read_col;
    logic [2:0]  in_read_page;
    logic [1:0]  in_req_type;
    logic        accept;

    assign in_font_addr   = s_tdata[11:0];
    assign in_font_byte   = s_tdata[19:12];
    assign in_char_code   = s_tdata[27:20];
    assign in_pos_x       = s_tdata[35:28];
    assign in_pos_y       = s_tdata[43:36];
    assign in_ink         = s_tdata[45:44];
    assign in_transparent = s_tdata[46];
    assign in_read_col    = s_tdata[53:47];
    assign in_read_page   = s_tdata[56:54];
    assign in_req_type    = s_tuser;

    // control state
    pgb_pkg::state_t    state_reg, state_next;
    logic [DISP_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic               out_valid_reg, out_valid_next;

    // datapath
    logic [CW-1:0]      prod_reg, prod_next;
    logic [8:0]         rec_reg, rec_next;
    logic [CW-1:0]      fptr_reg, fptr_next;
    logic [5:0]         cols_reg, cols_next;
    logic [5:0]         col_i_reg, col_i_next;
    logic [3:0]         row_j_reg, row_j_next;
    logic [7:0]         px_reg, px_next;
    logic [7:0]         py_reg, py_next;
    logic [7:0]         data_reg, data_next;
    logic [7:0]         code_reg, code_next;
    logic [7:0]         x_reg, x_next;
    logic [7:0]         y_reg, y_next;
    logic [1:0]         ink_reg, ink_next;
    logic               transp_reg, transp_next;
    logic               rd_ok_reg, rd_ok_next;
    logic [7:0]         res_value_reg, res_value_next;
    logic               res_bad_reg, res_bad_next;
    logic [7:0]         out_value_reg, out_value_next;
    logic               out_bad_reg, out_bad_next;

    // memories
    logic [7:0]         font_mem [FONT_BYTES];
    logic               font_we, font_re;
    logic [FONT_AW-1:0] font_waddr, font_raddr;
    logic [7:0]         font_wdata, font_rdata_reg;
    logic [7:0]         disp_mem [DISP_DEPTH];
    logic               disp_we, disp_re;
    logic [DISP_AW-1:0] disp_waddr, disp_raddr;
    logic [7:0]         disp_wdata, disp_rdata_reg;

    // shared multiplier and helpers
    logic [pgb_pkg::MUL_A_W-1:0] mul_a;
    logic [pgb_pkg::MUL_B_W-1:0] mul_b;
    logic [CW-1:0]               mul_p;
    logic [pgb_pkg::ROWS_W-1:0]  rows;
    logic                        glyph_bad;
    logic [7:0]                  cols_sat;
    logic [7:0]                  ink_byte;
    logic                        px_ok, py_ok, lo_ok;
    logic [DISP_AW-1:0]          up_addr, lo_addr, in_rd_addr;
    logic                        in_rd_ok;
    logic [15:0]                 bits16, mask16;
    logic [7:0]                  up_byte, lo_byte;
    logic                        last_row, last_col;
    logic                        out_free;

    assign accept   = s_tvalid & s_tready;
    assign s_tready = (state_reg == pgb_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_bad_reg;
    assign out_free = !out_valid_reg || m_tready;

    assign rows      = pgb_pkg::ROWS_W'((7'(cfg.glyph_height) + 7'd7) >> 3);
    assign mul_p     = CW'(mul_a) * CW'(mul_b);
    assign glyph_bad = (code_reg < cfg.first_code)
                       || ((32'(prod_reg) + 32'(rec_reg)) > FONT_BYTES);
    assign cols_sat  = (font_rdata_reg > 8'(cfg.glyph_width)) ? 8'(cfg.glyph_width)
                                                               : font_rdata_reg;

    always_comb
    begin
        case (ink_reg)
            pgb_pkg::INK_SET:    ink_byte = font_rdata_reg;
            pgb_pkg::INK_INVERT: ink_byte = ~font_rdata_reg;
            default:             ink_byte = 8'h00;
        endcase
    end

    assign px_ok   = 32'(px_reg) < SCREEN_COLUMNS;
    assign py_ok   = 32'(py_reg) < (SCREEN_PAGES * 8);
    assign lo_ok   = (py_reg[2:0] != 3'd0) && ((32'(py_reg[7:3]) + 1) < SCREEN_PAGES);
    assign up_addr = DISP_AW'(32'(py_reg[7:3]) * SCREEN_COLUMNS + 32'(px_reg));
    assign lo_addr = DISP_AW'(32'(up_addr) + SCREEN_COLUMNS);

    assign in_rd_ok   = (32'(in_read_col) < SCREEN_COLUMNS)
                        && (32'(in_read_page) < SCREEN_PAGES);
    assign in_rd_addr = DISP_AW'(32'(in_read_page) * SCREEN_COLUMNS + 32'(in_read_col));

    // byte split across two pages, with the bits each page keeps
    assign bits16  = {8'h00, data_reg} << py_reg[2:0];
    assign mask16  = 16'h00ff << py_reg[2:0];
    assign up_byte = (transp_reg ? disp_rdata_reg : (disp_rdata_reg & ~mask16[7:0]))
                     | bits16[7:0];
    assign lo_byte = (transp_reg ? disp_rdata_reg : (disp_rdata_reg & ~mask16[15:8]))
                     | bits16[15:8];

    assign last_row = (4'(row_j_reg + 4'd1) == rows);
    assign last_col = (6'(col_i_reg + 6'd1) == cols_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pgb_pkg::ST_CLEAR:
            begin
                if (32'(clr_cnt_reg) == DISP_DEPTH - 1)
                    state_next = pgb_pkg::ST_IDLE;
            end
            pgb_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_req_type)
                        pgb_pkg::REQ_DRAW: state_next = pgb_pkg::ST_MUL1;
                        pgb_pkg::REQ_READ: state_next = pgb_pkg::ST_DISP_DATA;
                        default:           state_next = pgb_pkg::ST_DONE;
                    endcase
                end
            end
            pgb_pkg::ST_MUL1:      state_next = pgb_pkg::ST_MUL2;
            pgb_pkg::ST_MUL2:      state_next = pgb_pkg::ST_CHECK;
            pgb_pkg::ST_CHECK:
                state_next = glyph_bad ? pgb_pkg::ST_DONE : pgb_pkg::ST_COUNT;
            pgb_pkg::ST_COUNT:
            begin
                if (cols_sat == 8'd0 || rows == '0)
                    state_next = pgb_pkg::ST_DONE;
                else
                    state_next = pgb_pkg::ST_FONT_RD;
            end
            pgb_pkg::ST_FONT_RD:   state_next = pgb_pkg::ST_FONT_DATA;
            pgb_pkg::ST_FONT_DATA:
                state_next = (px_ok && py_ok) ? pgb_pkg::ST_UP_RD : pgb_pkg::ST_NEXT;
            pgb_pkg::ST_UP_RD:     state_next = pgb_pkg::ST_UP_WR;
            pgb_pkg::ST_UP_WR:
                state_next = lo_ok ? pgb_pkg::ST_LO_RD : pgb_pkg::ST_NEXT;
            pgb_pkg::ST_LO_RD:     state_next = pgb_pkg::ST_LO_WR;
            pgb_pkg::ST_LO_WR:     state_next = pgb_pkg::ST_NEXT;
            pgb_pkg::ST_NEXT:
                state_next = (last_row && last_col) ? pgb_pkg::ST_DONE : pgb_pkg::ST_FONT_RD;
            pgb_pkg::ST_DISP_DATA: state_next = pgb_pkg::ST_DONE;
            pgb_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = pgb_pkg::ST_IDLE;
            end
            default:               state_next = pgb_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer: memory strobes and datapath updates
    always_comb
    begin
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        prod_next      = prod_reg;
        rec_next       = rec_reg;
        fptr_next      = fptr_reg;
        cols_next      = cols_reg;
        col_i_next     = col_i_reg;
        row_j_next     = row_j_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        data_next      = data_reg;
        code_next      = code_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ink_next       = ink_reg;
        transp_next    = transp_reg;
        rd_ok_next     = rd_ok_reg;
        res_value_next = res_value_reg;
        res_bad_next   = res_bad_reg;
        out_value_next = out_value_reg;
        out_bad_next   = out_bad_reg;
        mul_a          = 9'(cfg.glyph_width);
        mul_b          = 8'(rows);
        font_we        = 1'b0;
        font_waddr     = FONT_AW'(in_font_addr);
        font_wdata     = in_font_byte;
        font_re        = 1'b0;
        font_raddr     = FONT_AW'(fptr_reg);
        disp_we        = 1'b0;
        disp_waddr     = up_addr;
        disp_wdata     = up_byte;
        disp_re        = 1'b0;
        disp_raddr     = up_addr;

        if (m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            pgb_pkg::ST_CLEAR:
            begin
                disp_we      = 1'b1;
                disp_waddr   = clr_cnt_reg;
                disp_wdata   = 8'h00;
                clr_cnt_next = DISP_AW'(clr_cnt_reg + 1'b1);
            end
            pgb_pkg::ST_IDLE:
            begin
                res_value_next = 8'h00;
                res_bad_next   = 1'b0;
                code_next      = in_char_code;
                x_next         = in_pos_x;
                y_next         = in_pos_y;
                ink_next       = in_ink;
                transp_next    = in_transparent;
                rd_ok_next     = in_rd_ok;
                disp_raddr     = in_rd_addr;
                if (accept && in_req_type == pgb_pkg::REQ_LOAD
                    && 32'(in_font_addr) < FONT_BYTES)
                    font_we = 1'b1;
                if (accept && in_req_type == pgb_pkg::REQ_READ)
                    disp_re = 1'b1;
            end
            pgb_pkg::ST_MUL1:
            begin
                prod_next = mul_p;
            end
            pgb_pkg::ST_MUL2:
            begin
                mul_a     = 9'(prod_reg[8:0] + 9'd1);
                mul_b     = 8'(code_reg - cfg.first_code);
                rec_next  = 9'(prod_reg[8:0] + 9'd1);
                prod_next = mul_p;
            end
            pgb_pkg::ST_CHECK:
            begin
                res_bad_next = glyph_bad;
                font_re      = !glyph_bad;
                font_raddr   = FONT_AW'(prod_reg);
                fptr_next    = CW'(prod_reg + 1'b1);
            end
            pgb_pkg::ST_COUNT:
            begin
                cols_next      = 6'(cols_sat);
                res_value_next = cols_sat;
                col_i_next     = '0;
                row_j_next     = '0;
                px_next        = x_reg;
                py_next        = y_reg;
            end
            pgb_pkg::ST_FONT_RD:
            begin
                font_re = 1'b1;
            end
            pgb_pkg::ST_FONT_DATA:
            begin
                data_next = ink_byte;
                fptr_next = CW'(fptr_reg + 1'b1);
            end
            pgb_pkg::ST_UP_RD:
            begin
                disp_re = 1'b1;
            end
            pgb_pkg::ST_UP_WR:
            begin
                disp_we = 1'b1;
            end
            pgb_pkg::ST_LO_RD:
            begin
                disp_re    = 1'b1;
                disp_raddr = lo_addr;
            end
            pgb_pkg::ST_LO_WR:
            begin
                disp_we    = 1'b1;
                disp_waddr = lo_addr;
                disp_wdata = lo_byte;
            end
            pgb_pkg::ST_NEXT:
            begin
                if (last_row)
                begin
                    row_j_next = '0;
                    col_i_next = 6'(col_i_reg + 6'd1);
                    px_next    = 8'(px_reg + 8'd1);
                    py_next    = y_reg;
                end
                else
                begin
                    row_j_next = 4'(row_j_reg + 4'd1);
                    py_next    = 8'(py_reg + 8'd8);
                end
            end
            pgb_pkg::ST_DISP_DATA:
            begin
                res_value_next = rd_ok_reg ? disp_rdata_reg : 8'h00;
            end
            pgb_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_bad_next   = res_bad_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pgb_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        rec_reg       <= rec_next;
        fptr_reg      <= fptr_next;
        cols_reg      <= cols_next;
        col_i_reg     <= col_i_next;
        row_j_reg     <= row_j_next;
        px_reg        <= px_next;
        py_reg        <= py_next;
        data_reg      <= data_next;
        code_reg      <= code_next;
        x_reg         <= x_next;
        y_reg         <= y_next;
        ink_reg       <= ink_next;
        transp_reg    <= transp_next;
        rd_ok_reg     <= rd_ok_next;
        res_value_reg <= res_value_next;
        res_bad_reg   <= res_bad_next;
        out_value_reg <= out_value_next;
        out_bad_reg   <= out_bad_next;
    end

    always_ff @(posedge clk)
    begin
        if (font_we)
            font_mem[font_waddr] <= font_wdata;
        if (font_re)
            font_rdata_reg <= font_mem[font_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (disp_we)
            disp_mem[disp_waddr] <= disp_wdata;
        if (disp_re)
            disp_rdata_reg <= disp_mem[disp_raddr];
    end

endmodule

/* rtl/core/pgb_checker.sv */
// pgb_checker: port-level assertions for the glyph blitter, bound to the top level.
// Depends on page_display_glyph_blitter ports only.
module pgb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [0:0] m_tuser
);

    // one word at a time: busy straight after taking a word
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("s_tready high right after an accepted word");

    // a new result only appears as the sequencer finishes
    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised while idle");

    // a bad glyph draws nothing and returns zero
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'h00))
        else $error("bad glyph with non-zero value");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result word changed");

endmodule

bind page_display_glyph_blitter pgb_checker u_pgb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
